@@ rtl/sdsh_pkg.sv @@
// Shared types, codes and command frame tables for the SD SPI host sequencer.
package sdsh_pkg;

    // Block and counter sizes
    localparam int BLOCK_BYTES = 512;
    localparam int COUNT_W     = $clog2(BLOCK_BYTES) + 1;
    localparam int POLL_W      = 20;
    localparam int PHASE_W     = 5;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Command codes
    localparam logic [2:0] CMD_IDLE   = 3'd0;
    localparam logic [2:0] CMD_GO     = 3'd1;
    localparam logic [2:0] CMD_IFCOND = 3'd2;
    localparam logic [2:0] CMD_APPOP  = 3'd3;
    localparam logic [2:0] CMD_OCR    = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;
    localparam logic [2:0] CMD_WRITE  = 3'd6;

    // Completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_R1_ERR   = 2'd1;
    localparam logic [1:0] ST_TOKEN_TO = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TOKEN_LIMIT = 2'd1;
    localparam logic [1:0] REG_IDLE_COUNT  = 2'd2;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 5'd0;
    localparam logic [PHASE_W-1:0] PH_CLOCKS = 5'd1;
    localparam logic [PHASE_W-1:0] PH_FRAME  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_POLL   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_GAP    = 5'd4;
    localparam logic [PHASE_W-1:0] PH_FRAME2 = 5'd5;
    localparam logic [PHASE_W-1:0] PH_POLL2  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_TRAIL  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_TAIL   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_TOKEN  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_READ   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_CRCR   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_WTOKEN = 5'd12;
    localparam logic [PHASE_W-1:0] PH_WDATA  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_WCRC   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_WRESP  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_BUSY   = 5'd16;

    // Byte values on the link
    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] TOKEN_START  = 8'hFE;
    localparam logic [7:0] CMD17_BYTE   = 8'h51;
    localparam logic [7:0] CMD24_BYTE   = 8'h58;
    localparam logic [7:0] DRESP_MASK   = 8'h1F;
    localparam logic [7:0] DRESP_ACCEPT = 8'h05;
    localparam logic [7:0] R1_ERR_MASK  = 8'hFE;

    // Result fields of one transfer
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       select_active;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] response_byte;
    } t_result;

    // Fixed frames: CMD0, CMD8, CMD55, CMD58, ACMD41
    localparam logic [7:0] FRAMES [0:4][0:5] = '{
        '{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h95},
        '{8'h48, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h87},
        '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
        '{8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
        '{8'h69, 8'h40, 8'h00, 8'h00, 8'h00, 8'hFF}
    };

    // Byte idx of the command frame; second selects the ACMD41 frame
    function automatic logic [7:0] f_frame_byte(input logic [2:0]  cmd,
                                                input logic        second,
                                                input logic [2:0]  idx,
                                                input logic [31:0] addr);
        logic [7:0] b;
        b = BYTE_IDLE;
        if (idx < 3'd6) begin
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                case (idx)
                    3'd0:    b = (cmd == CMD_READ) ? CMD17_BYTE : CMD24_BYTE;
                    3'd1:    b = addr[31:24];
                    3'd2:    b = addr[23:16];
                    3'd3:    b = addr[15:8];
                    3'd4:    b = addr[7:0];
                    default: b = BYTE_IDLE;
                endcase
            end else if (second) begin
                b = FRAMES[4][idx];
            end else if (cmd == CMD_GO) begin
                b = FRAMES[0][idx];
            end else if (cmd == CMD_IFCOND) begin
                b = FRAMES[1][idx];
            end else if (cmd == CMD_APPOP) begin
                b = FRAMES[2][idx];
            end else begin
                b = FRAMES[3][idx];
            end
        end
        return b;
    endfunction

endpackage

@@ rtl/sd_spi_host_sequencer_unit.sv @@
// SD card SPI-mode host sequencer: one result per SPI byte exchange item.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_valid / o_ready          | i_opcode i_command i_block_address
//           |                            | i_rx_byte i_payload_byte
//  result   | o_valid / i_ready          | o_send_valid o_send_byte o_select_active
//           |                            | o_data_valid o_data_byte o_done_res
//           |                            | o_status o_response_byte
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// The sequencer state and the result register update at the same edge, so one
// item per clock is accepted while results are taken.
// The result register is the only buffer; o_ready drops only while it holds a
// result that the consumer stalls on.
// Synchronous active-low reset returns to idle with default limits.
// Config writes are always taken (o_cfg_ready is tied high).
module sd_spi_host_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_block_address,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_payload_byte,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_select_active,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [7:0]  o_response_byte,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import sdsh_pkg::*;

    // config registers
    logic [7:0]        r_poll_limit;
    logic [POLL_W-1:0] r_token_limit;
    logic [7:0]        r_idle_count;

    // sequencer state
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic [2:0]         r_cmd,     n_cmd;
    logic [31:0]        r_addr,    n_addr;
    logic [COUNT_W-1:0] r_bcnt,    n_bcnt;
    logic [POLL_W-1:0]  r_pcnt,    n_pcnt;
    logic [7:0]         r_resp,    n_resp;
    logic [1:0]         r_endst,   n_endst;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic               in_fire;
    logic               r1_err;
    logic [COUNT_W-1:0] bcnt_inc;
    logic               sv, sel, dv, done;
    logic [7:0]         sb, db;
    logic [1:0]         st;

    assign o_ready     = !r_out_valid || i_ready;
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign r1_err      = (i_rx_byte & R1_ERR_MASK) != 8'h00;
    assign bcnt_inc    = r_bcnt + COUNT_W'(1);

    // next state and result for one accepted transfer
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_bcnt  = r_bcnt;
        n_pcnt  = r_pcnt;
        n_resp  = r_resp;
        n_endst = r_endst;
        sv = 1'b0; sb = 8'h00; sel = 1'b0; dv = 1'b0; db = 8'h00;
        done = 1'b0; st = ST_OK;

        if (i_opcode == OP_START) begin
            if (i_command <= CMD_WRITE) begin
                n_cmd   = i_command;
                n_addr  = i_block_address;
                n_endst = ST_OK;
                n_pcnt  = '0;
                n_bcnt  = COUNT_W'(1);
                sv      = 1'b1;
                if (i_command == CMD_IDLE) begin
                    n_phase = PH_CLOCKS;
                    sb      = BYTE_IDLE;
                end else begin
                    n_phase = PH_FRAME;
                    sb      = f_frame_byte(i_command, 1'b0, 3'd0, i_block_address);
                    sel     = 1'b1;
                end
            end
        end else begin
            unique case (r_phase)
                PH_CLOCKS: begin
                    if (r_bcnt < {{(COUNT_W-8){1'b0}}, r_idle_count}) begin
                        n_bcnt = bcnt_inc;
                        sv = 1'b1; sb = BYTE_IDLE;
                    end else begin
                        n_phase = PH_IDLE; done = 1'b1; st = ST_OK;
                    end
                end
                PH_FRAME, PH_FRAME2: begin
                    sv = 1'b1; sel = 1'b1;
                    if (r_bcnt < COUNT_W'(6)) begin
                        sb     = f_frame_byte(r_cmd, r_phase == PH_FRAME2, r_bcnt[2:0], r_addr);
                        n_bcnt = bcnt_inc;
                    end else begin
                        n_phase = (r_phase == PH_FRAME) ? PH_POLL : PH_POLL2;
                        n_pcnt  = POLL_W'(1);
                        sb      = BYTE_IDLE;
                    end
                end
                PH_POLL, PH_POLL2: begin
                    if (i_rx_byte == BYTE_IDLE &&
                        r_pcnt < {{(POLL_W-8){1'b0}}, r_poll_limit}) begin
                        n_pcnt = r_pcnt + POLL_W'(1);
                        sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                    end else begin
                        n_resp = i_rx_byte;
                        if (r_cmd == CMD_APPOP && r_phase == PH_POLL) begin
                            // CMD55 answer ignored, ACMD41 follows
                            n_phase = PH_GAP;
                            sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                        end else if (r_cmd == CMD_GO) begin
                            n_phase = PH_IDLE; done = 1'b1;
                            st = r1_err ? ST_R1_ERR : ST_OK;
                        end else if (r_cmd == CMD_IFCOND || r_cmd == CMD_OCR) begin
                            n_endst = r1_err ? ST_R1_ERR : ST_OK;
                            n_phase = PH_TRAIL;
                            n_bcnt  = '0;
                            sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                        end else if (r_cmd == CMD_APPOP) begin
                            n_endst = r1_err ? ST_R1_ERR : ST_OK;
                            n_phase = PH_TAIL;
                            sv = 1'b1; sb = BYTE_IDLE;
                        end else if (r_cmd == CMD_READ) begin
                            if (i_rx_byte != 8'h00) begin
                                n_phase = PH_IDLE; done = 1'b1; st = ST_R1_ERR;
                            end else begin
                                n_phase = PH_TOKEN;
                                n_pcnt  = POLL_W'(1);
                                sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                            end
                        end else if (r_cmd == CMD_WRITE) begin
                            sv = 1'b1; sb = TOKEN_START;
                            if (i_rx_byte != 8'h00) begin
                                n_endst = ST_R1_ERR;
                                n_phase = PH_TAIL;
                            end else begin
                                n_phase = PH_WTOKEN;
                                sel     = 1'b1;
                            end
                        end else begin
                            n_phase = PH_IDLE; done = 1'b1; st = ST_OK;
                        end
                    end
                end
                PH_GAP: begin
                    n_phase = PH_FRAME2;
                    n_bcnt  = COUNT_W'(1);
                    sv = 1'b1; sel = 1'b1;
                    sb = f_frame_byte(CMD_APPOP, 1'b1, 3'd0, r_addr);
                end
                PH_TRAIL: begin
                    // R7 / OCR trailer bytes
                    n_bcnt = bcnt_inc;
                    dv = 1'b1; db = i_rx_byte;
                    if (bcnt_inc < COUNT_W'(4)) begin
                        sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                    end else if (r_cmd == CMD_OCR) begin
                        n_phase = PH_TAIL;
                        sv = 1'b1; sb = BYTE_IDLE;
                    end else begin
                        n_phase = PH_IDLE; done = 1'b1; st = r_endst;
                    end
                end
                PH_TOKEN: begin
                    sv = 1'b1; sb = BYTE_IDLE;
                    if (i_rx_byte == TOKEN_START) begin
                        n_phase = PH_READ;
                        n_bcnt  = '0;
                        sel     = 1'b1;
                    end else if (r_pcnt >= r_token_limit) begin
                        n_endst = ST_TOKEN_TO;
                        n_phase = PH_TAIL;
                    end else begin
                        n_pcnt = r_pcnt + POLL_W'(1);
                        sel    = 1'b1;
                    end
                end
                PH_READ: begin
                    n_bcnt = bcnt_inc;
                    if (bcnt_inc >= COUNT_W'(BLOCK_BYTES)) begin
                        n_phase = PH_CRCR;
                        n_bcnt  = '0;
                    end
                    sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                    dv = 1'b1; db = i_rx_byte;
                end
                PH_CRCR: begin
                    n_bcnt = bcnt_inc;
                    sv = 1'b1; sb = BYTE_IDLE;
                    if (bcnt_inc < COUNT_W'(2)) begin
                        sel = 1'b1;
                    end else begin
                        n_endst = ST_OK;
                        n_phase = PH_TAIL;
                    end
                end
                PH_WTOKEN: begin
                    n_phase = PH_WDATA;
                    n_bcnt  = COUNT_W'(1);
                    sv = 1'b1; sb = i_payload_byte; sel = 1'b1;
                end
                PH_WDATA: begin
                    sv = 1'b1; sel = 1'b1;
                    if (r_bcnt < COUNT_W'(BLOCK_BYTES)) begin
                        n_bcnt = bcnt_inc;
                        sb     = i_payload_byte;
                    end else begin
                        n_phase = PH_WCRC;
                        n_bcnt  = '0;
                        sb      = BYTE_IDLE;
                    end
                end
                PH_WCRC: begin
                    n_bcnt = bcnt_inc;
                    if (bcnt_inc >= COUNT_W'(2)) begin
                        n_phase = PH_WRESP;
                    end
                    sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                end
                PH_WRESP: begin
                    n_resp = i_rx_byte;
                    if ((i_rx_byte & DRESP_MASK) != DRESP_ACCEPT) begin
                        n_phase = PH_IDLE; done = 1'b1; st = ST_REJECT;
                    end else begin
                        n_phase = PH_BUSY;
                        sv = 1'b1; sb = BYTE_IDLE; sel = 1'b1;
                    end
                end
                PH_BUSY: begin
                    sv = 1'b1; sb = BYTE_IDLE;
                    if (i_rx_byte == 8'h00) begin
                        sel = 1'b1;
                    end else begin
                        n_endst = ST_OK;
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    n_phase = PH_IDLE; done = 1'b1; st = r_endst;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // field zeroing when the qualifying flag is low
        n_out.send_valid    = sv;
        n_out.send_byte     = sv ? sb : 8'h00;
        n_out.select_active = sv ? sel : 1'b0;
        n_out.data_valid    = dv;
        n_out.data_byte     = dv ? db : 8'h00;
        n_out.done_res      = done;
        n_out.status        = done ? st : ST_OK;
        n_out.response_byte = n_resp;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit  <= 8'd10;
            r_token_limit <= POLL_W'(100000);
            r_idle_count  <= 8'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POLL_LIMIT:  r_poll_limit  <= i_cfg_data[7:0];
                REG_TOKEN_LIMIT: r_token_limit <= i_cfg_data;
                REG_IDLE_COUNT:  r_idle_count  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state, updated per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= CMD_IDLE;
            r_addr  <= '0;
            r_bcnt  <= '0;
            r_pcnt  <= '0;
            r_resp  <= BYTE_IDLE;
            r_endst <= ST_OK;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_bcnt  <= n_bcnt;
            r_pcnt  <= n_pcnt;
            r_resp  <= n_resp;
            r_endst <= n_endst;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_send_valid    = r_out.send_valid;
    assign o_send_byte     = r_out.send_byte;
    assign o_select_active = r_out.select_active;
    assign o_data_valid    = r_out.data_valid;
    assign o_data_byte     = r_out.data_byte;
    assign o_done_res      = r_out.done_res;
    assign o_status        = r_out.status;
    assign o_response_byte = r_out.response_byte;

endmodule

@@ rtl/sdsh_checker.sv @@
// Port-level checker for the SD SPI host sequencer, with its bind.
module sdsh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic        o_send_valid,
    input  logic [7:0]  o_send_byte,
    input  logic        o_select_active,
    input  logic        o_data_valid,
    input  logic [7:0]  o_data_byte,
    input  logic        o_done_res,
    input  logic [1:0]  o_status
);
    import sdsh_pkg::*;

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_send_byte) && $stable(o_status)
            && $stable(o_done_res) && $stable(o_data_byte))
        else $error("stalled result changed");

    // no exchange requested means no byte and no chip select
    a_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_valid |-> o_send_byte == 8'h00 && !o_select_active)
        else $error("idle exchange carries byte or select");

    // no data flag means a zero data byte
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_valid |-> o_data_byte == 8'h00)
        else $error("data byte without data flag");

    // status only reported with completion
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == ST_OK)
        else $error("status without completion");

    // a full result buffer under stall blocks new input
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while result stalled");

endmodule

bind sd_spi_host_sequencer_unit sdsh_checker u_sdsh_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the SD card SPI-mode host sequencer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdsh_pkg::*;

    localparam logic [2:0]  CMD_NONE      = 3'd7;   // start code with no command behind it
    localparam logic [1:0]  REG_UNUSED    = 2'd3;   // index past the register map
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          NUM_SETTINGS  = 6;
    localparam int          SETTING_ITEMS = 80;
    localparam int          MIN_COMMANDS  = 3;
    localparam int          MAX_REPORTS   = 10;

    // Expected link transfers, predicted from every accepted input transfer
    class exchange_checker;
        logic [7:0]  poll_limit;
        logic [19:0] token_limit;
        logic [7:0]  idle_count;
        logic [4:0]  phase;
        logic [2:0]  cur_cmd;
        logic [31:0] cur_addr;
        logic [9:0]  count;
        logic [19:0] polls;
        logic [7:0]  last_r1;
        logic [1:0]  end_code;
        t_result     expected_exchanges [$];
        int          mismatches;

        function new();
            poll_limit  = 8'd10;
            token_limit = 20'd100000;
            idle_count  = 8'd10;
            phase       = PH_IDLE;
            cur_cmd     = CMD_IDLE;
            cur_addr    = '0;
            count       = '0;
            polls       = '0;
            last_r1     = BYTE_IDLE;
            end_code    = ST_OK;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] val);
            case (idx)
                REG_POLL_LIMIT:  poll_limit  = val[7:0];
                REG_TOKEN_LIMIT: token_limit = val;
                REG_IDLE_COUNT:  idle_count  = val[7:0];
                default: ;
            endcase
        endfunction

        // Byte idx of the current six-byte command frame
        function logic [7:0] frame_byte(logic second, logic [9:0] idx);
            logic [47:0] f;
            int          i;
            i = idx;
            if (cur_cmd == CMD_READ || cur_cmd == CMD_WRITE) begin
                f = {(cur_cmd == CMD_READ) ? CMD17_BYTE : CMD24_BYTE, cur_addr, BYTE_IDLE};
            end else if (second) begin
                f = 48'h69_4000_0000_FF;
            end else begin
                case (cur_cmd)
                    CMD_GO:     f = 48'h40_0000_0000_95;
                    CMD_IFCOND: f = 48'h48_0000_01AA_87;
                    CMD_APPOP:  f = 48'h77_0000_0000_FF;
                    default:    f = 48'h7A_0000_0000_FF;
                endcase
            end
            return f[47 - 8 * i -: 8];
        endfunction

        // One result; fields that are not flagged valid read as zero
        function t_result exchange(logic sv, logic [7:0] sb, logic sel, logic dv,
                                   logic [7:0] db, logic done, logic [1:0] st);
            t_result r;
            r.send_valid    = sv;
            r.send_byte     = sv ? sb : 8'h00;
            r.select_active = sv ? sel : 1'b0;
            r.data_valid    = dv;
            r.data_byte     = dv ? db : 8'h00;
            r.done_res      = done;
            r.status        = done ? st : ST_OK;
            r.response_byte = last_r1;
            return r;
        endfunction

        function t_result complete(logic [1:0] st);
            phase = PH_IDLE;
            return exchange(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, st);
        endfunction

        // Next sequencer step for one accepted input transfer
        function void note_item(logic op, logic [2:0] cmd, logic [31:0] addr,
                                logic [7:0] rx, logic [7:0] pay);
            t_result r;
            logic    err;
            r = exchange(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
            if (op == OP_START) begin
                if (cmd <= CMD_WRITE) begin
                    cur_cmd  = cmd;
                    cur_addr = addr;
                    end_code = ST_OK;
                    polls    = '0;
                    count    = 10'd1;
                    if (cmd == CMD_IDLE) begin
                        phase = PH_CLOCKS;
                        r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                    end else begin
                        phase = PH_FRAME;
                        r = exchange(1'b1, frame_byte(1'b0, 10'd0), 1'b1, 1'b0, 8'h00,
                                     1'b0, ST_OK);
                    end
                end
            end else begin
                case (phase)
                    PH_CLOCKS: begin
                        if (count < idle_count) begin
                            count++;
                            r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            r = complete(ST_OK);
                        end
                    end
                    PH_FRAME, PH_FRAME2: begin
                        if (count < 10'd6) begin
                            r = exchange(1'b1, frame_byte(phase == PH_FRAME2, count), 1'b1,
                                         1'b0, 8'h00, 1'b0, ST_OK);
                            count++;
                        end else begin
                            phase = (phase == PH_FRAME) ? PH_POLL : PH_POLL2;
                            polls = 20'd1;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_POLL, PH_POLL2: begin
                        if (rx == BYTE_IDLE && polls < poll_limit) begin
                            polls++;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            last_r1 = rx;
                            err = |(rx & R1_ERR_MASK);
                            if (cur_cmd == CMD_APPOP && phase == PH_POLL) begin
                                // CMD55 answer does not matter, ACMD41 follows
                                phase = PH_GAP;
                                r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                            end else if (cur_cmd == CMD_GO) begin
                                r = complete(err ? ST_R1_ERR : ST_OK);
                            end else if (cur_cmd == CMD_IFCOND || cur_cmd == CMD_OCR) begin
                                end_code = err ? ST_R1_ERR : ST_OK;
                                phase    = PH_TRAIL;
                                count    = '0;
                                r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                            end else if (cur_cmd == CMD_APPOP) begin
                                end_code = err ? ST_R1_ERR : ST_OK;
                                phase    = PH_TAIL;
                                r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                            end else if (cur_cmd == CMD_READ) begin
                                if (rx != 8'h00) begin
                                    r = complete(ST_R1_ERR);
                                end else begin
                                    phase = PH_TOKEN;
                                    polls = 20'd1;
                                    r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0,
                                                 ST_OK);
                                end
                            end else if (cur_cmd == CMD_WRITE) begin
                                if (rx != 8'h00) begin
                                    // rejected command: token goes out deselected
                                    end_code = ST_R1_ERR;
                                    phase    = PH_TAIL;
                                    r = exchange(1'b1, TOKEN_START, 1'b0, 1'b0, 8'h00, 1'b0,
                                                 ST_OK);
                                end else begin
                                    phase = PH_WTOKEN;
                                    r = exchange(1'b1, TOKEN_START, 1'b1, 1'b0, 8'h00, 1'b0,
                                                 ST_OK);
                                end
                            end else begin
                                r = complete(ST_OK);
                            end
                        end
                    end
                    PH_GAP: begin
                        phase = PH_FRAME2;
                        count = 10'd1;
                        r = exchange(1'b1, frame_byte(1'b1, 10'd0), 1'b1, 1'b0, 8'h00,
                                     1'b0, ST_OK);
                    end
                    PH_TRAIL: begin
                        count++;
                        if (count < 10'd4) begin
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b1, rx, 1'b0, ST_OK);
                        end else if (cur_cmd == CMD_OCR) begin
                            phase = PH_TAIL;
                            r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b1, rx, 1'b0, ST_OK);
                        end else begin
                            phase = PH_IDLE;
                            r = exchange(1'b0, 8'h00, 1'b0, 1'b1, rx, 1'b1, end_code);
                        end
                    end
                    PH_TOKEN: begin
                        if (rx == TOKEN_START) begin
                            phase = PH_READ;
                            count = '0;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else if (polls >= token_limit) begin
                            end_code = ST_TOKEN_TO;
                            phase    = PH_TAIL;
                            r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            polls++;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_READ: begin
                        count++;
                        if (count >= BLOCK_BYTES) begin
                            phase = PH_CRCR;
                            count = '0;
                        end
                        r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b1, rx, 1'b0, ST_OK);
                    end
                    PH_CRCR: begin
                        count++;
                        if (count < 10'd2) begin
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            end_code = ST_OK;
                            phase    = PH_TAIL;
                            r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_WTOKEN: begin
                        phase = PH_WDATA;
                        count = 10'd1;
                        r = exchange(1'b1, pay, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                    end
                    PH_WDATA: begin
                        if (count < BLOCK_BYTES) begin
                            count++;
                            r = exchange(1'b1, pay, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            phase = PH_WCRC;
                            count = '0;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_WCRC: begin
                        count++;
                        if (count >= 10'd2) phase = PH_WRESP;
                        r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                    end
                    PH_WRESP: begin
                        last_r1 = rx;
                        if ((rx & DRESP_MASK) != DRESP_ACCEPT) begin
                            r = complete(ST_REJECT);
                        end else begin
                            phase = PH_BUSY;
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_BUSY: begin
                        if (rx == 8'h00) begin
                            r = exchange(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
                        end else begin
                            end_code = ST_OK;
                            phase    = PH_TAIL;
                            r = exchange(1'b1, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
                        end
                    end
                    PH_TAIL: begin
                        r = complete(end_code);
                    end
                    default: begin
                        phase = PH_IDLE;
                    end
                endcase
            end
            expected_exchanges.push_back(r);
        endfunction

        function string show(t_result r);
            return $sformatf("sv=%0d sb=%h sel=%0d dv=%0d db=%h done=%0d st=%0d rsp=%h",
                             r.send_valid, r.send_byte, r.select_active, r.data_valid,
                             r.data_byte, r.done_res, r.status, r.response_byte);
        endfunction

        // Compare one accepted result transfer with the oldest prediction
        function void check_exchange(t_result got);
            t_result want;
            logic    bad;
            if (expected_exchanges.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: %s", $realtime, show(got));
                return;
            end
            want = expected_exchanges.pop_front();
            bad = (got.send_valid !== want.send_valid) ||
                  (got.send_byte !== want.send_byte) ||
                  (got.select_active !== want.select_active) ||
                  (got.data_valid !== want.data_valid) ||
                  (got.data_byte !== want.data_byte) ||
                  (got.done_res !== want.done_res) ||
                  (got.status !== want.status) ||
                  (got.response_byte !== want.response_byte);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return expected_exchanges.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = OP_START;
    logic [2:0]  i_command = CMD_IDLE;
    logic [31:0] i_block_address = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_send_valid;
    logic [7:0]  o_send_byte;
    logic        o_select_active;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [7:0]  o_response_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_POLL_LIMIT;
    logic [19:0] i_cfg_data = '0;

    exchange_checker sb;
    int              cycles = 0;
    int              items_sent = 0;
    int              hold_left = 0;
    bit              smooth = 1'b0;      // no gaps and no stalls for the current command
    bit              cooperative = 1'b0; // card answers so the command runs to the end

    sd_spi_host_sequencer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_command      (i_command),
        .i_block_address(i_block_address),
        .i_rx_byte      (i_rx_byte),
        .i_payload_byte (i_payload_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_send_valid   (o_send_valid),
        .o_send_byte    (o_send_byte),
        .o_select_active(o_select_active),
        .o_data_valid   (o_data_valid),
        .o_data_byte    (o_data_byte),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_response_byte(o_response_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL sd_spi_host_sequencer_unit");
            $finish;
        end
    end

    // Transfer monitor: results are checked before new inputs are predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_exchange({o_send_valid, o_send_byte, o_select_active, o_data_valid,
                                   o_data_byte, o_done_res, o_status, o_response_byte});
            if (i_valid && o_ready)
                sb.note_item(i_opcode, i_command, i_block_address, i_rx_byte,
                             i_payload_byte);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result-side stalls
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!smooth && $urandom_range(0, 3) == 0) hold_left = pick_gap();
        end
    end

    // Card side: the byte clocked in, chosen from the phase the sequencer is in
    function automatic logic [7:0] card_reply();
        int r;
        r = $urandom_range(0, 99);
        case (sb.phase)
            PH_POLL, PH_POLL2: begin
                if (!cooperative && r < 45) return BYTE_IDLE;
                if (cooperative) return (sb.cur_cmd == CMD_GO) ? 8'h01 : 8'h00;
                r = $urandom_range(0, 9);
                if (r < 4) return 8'h00;
                if (r < 7) return 8'h01;
                return 8'($urandom_range(0, 255));
            end
            PH_TOKEN: begin
                if (r < 60) return BYTE_IDLE;
                if (r < 90 || cooperative) return TOKEN_START;
                return 8'($urandom_range(0, 255));
            end
            PH_WRESP: begin
                if (cooperative || r < 75)
                    return {3'($urandom_range(0, 7)), DRESP_ACCEPT[4:0]};
                return 8'($urandom_range(0, 255));
            end
            PH_BUSY: begin
                if (r < 70) return 8'h00;
                return 8'($urandom_range(0, 255));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One input transfer; returns at the falling edge after it is taken
    task automatic send_item(logic op, logic [2:0] cmd, logic [31:0] addr,
                             logic [7:0] rx, logic [7:0] pay);
        int gap;
        gap = (smooth || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_command       <= cmd;
        i_block_address <= addr;
        i_rx_byte       <= rx;
        i_payload_byte  <= pay;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Card byte transfer with random don't-care fields
    task automatic send_reply();
        send_item(OP_BYTE, 3'($urandom_range(0, 7)), $urandom, card_reply(),
                  8'($urandom_range(0, 255)));
    endtask

    // Start a command, then answer until it ends or the abort point comes
    task automatic run_command(logic [2:0] cmd, logic [31:0] addr, int abort_after);
        int n;
        n = 0;
        send_item(OP_START, cmd, addr, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        while (sb.phase != PH_IDLE && (abort_after == 0 || n < abort_after)) begin
            send_reply();
            n++;
        end
    endtask

    // Quiet input side and wait until all results are back
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(int setting);
        case (setting)
            0: begin
                write_reg(REG_POLL_LIMIT, 20'd255);
                write_reg(REG_TOKEN_LIMIT, 20'hFFFFF);
                write_reg(REG_IDLE_COUNT, 20'd255);
            end
            1: begin
                write_reg(REG_POLL_LIMIT, 20'd1);
                write_reg(REG_TOKEN_LIMIT, 20'd1);
                write_reg(REG_IDLE_COUNT, 20'd1);
            end
            2: begin
                // zero limits, and a write to an index with no register
                write_reg(REG_POLL_LIMIT, 20'd0);
                write_reg(REG_TOKEN_LIMIT, 20'd0);
                write_reg(REG_IDLE_COUNT, 20'd0);
                write_reg(REG_UNUSED, 20'($urandom));
            end
            default: begin
                // upper data bits are junk for the 8-bit registers
                write_reg(REG_POLL_LIMIT,
                          {12'($urandom_range(0, 4095)), 8'($urandom_range(1, 6))});
                write_reg(REG_TOKEN_LIMIT, (setting == 5) ? 20'($urandom_range(2, 8))
                                                          : 20'($urandom_range(24, 64)));
                write_reg(REG_IDLE_COUNT,
                          {12'($urandom_range(0, 4095)), 8'($urandom_range(1, 12))});
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'h0000_0000;
        if (r < 30) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // One random command, a noise transfer now and then
    task automatic random_command();
        int         r;
        int         abort_after;
        logic [2:0] cmd;
        smooth      = ($urandom_range(0, 3) == 0);
        cooperative = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 95);
        if (r < 3) begin
            send_reply();
            return;
        end
        if (r < 5) begin
            send_item(OP_START, CMD_NONE, $urandom, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            return;
        end
        if (r < 15)      cmd = CMD_IDLE;
        else if (r < 30) cmd = CMD_GO;
        else if (r < 45) cmd = CMD_IFCOND;
        else if (r < 65) cmd = CMD_APPOP;
        else if (r < 80) cmd = CMD_OCR;
        else if (r < 88) cmd = CMD_READ;
        else             cmd = CMD_WRITE;
        abort_after = 0;
        if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            if ($urandom_range(0, 99) < 65) abort_after = $urandom_range(1, 60);
        end else if ($urandom_range(0, 99) < 20) begin
            abort_after = $urandom_range(1, 12);
        end
        run_command(cmd, pick_address(), abort_after);
    endtask

    initial begin
        int first;
        int cmds;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: tight limits so the short cases end quickly
        smooth = 1'b1;
        write_reg(REG_POLL_LIMIT, 20'd2);
        write_reg(REG_TOKEN_LIMIT, 20'd1);
        write_reg(REG_IDLE_COUNT, 20'd1);
        i_cfg_valid <= 1'b0;
        send_item(OP_BYTE, CMD_IDLE, 32'h0, BYTE_IDLE, 8'h00);       // byte with no command
        send_item(OP_START, CMD_NONE, 32'hFFFF_FFFF, 8'h00, 8'hFF);  // unused start code
        // every command, each one cut short by the next start
        send_item(OP_START, CMD_IDLE, 32'h0, 8'h00, 8'h00);
        send_item(OP_START, CMD_GO, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(OP_START, CMD_IFCOND, 32'h0, 8'h00, 8'h00);
        send_item(OP_START, CMD_APPOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(OP_START, CMD_OCR, 32'h0, 8'h00, 8'h00);
        send_item(OP_START, CMD_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(OP_START, CMD_WRITE, 32'h8000_0001, 8'h00, 8'h00);
        // idle clocks with a count of one
        send_item(OP_START, CMD_IDLE, 32'h0, 8'h00, 8'h00);
        send_item(OP_BYTE, CMD_IDLE, 32'h0, 8'h00, 8'h00);
        // read with an R1 error: select drops, no further byte
        send_item(OP_START, CMD_READ, 32'hFFFF_FFFF, 8'h00, 8'h00);
        repeat (6) send_item(OP_BYTE, CMD_IDLE, 32'h0, BYTE_IDLE, 8'h00);
        send_item(OP_BYTE, CMD_IDLE, 32'h0, 8'h01, 8'h00);
        send_item(OP_BYTE, CMD_IDLE, 32'h0, 8'h00, 8'h00);

        // Random: several register settings, mostly well-formed card dialogs
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle();
            configure(s);
            first = items_sent;
            cmds  = 0;
            if (s == 3 || s == 4) begin
                cooperative = 1'b1;
                smooth      = 1'b0;
                run_command((s == 3) ? CMD_READ : CMD_WRITE, pick_address(), 0);
                cooperative = 1'b0;
            end
            while (items_sent - first < SETTING_ITEMS || cmds < MIN_COMMANDS) begin
                random_command();
                cmds++;
            end
            // finish whatever command is still running before the next write
            while (sb.phase != PH_IDLE) send_reply();
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS sd_spi_host_sequencer_unit");
        end else begin
            $display("FAIL sd_spi_host_sequencer_unit");
        end
        $finish;
    end

endmodule
